// ----- src/lsepg_pkg.sv -----
// shared constants and types for the led strip effect pixel generator
package lsepg_pkg;

  localparam int PIXELS_MAX = 1024;
  localparam int MIN_WAIT   = 25;

  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int STEP_W = 16;
  localparam int WAIT_W = 16;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int EFF_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DIVD_W  = 18;
  localparam int DIVS_W  = CNT_W;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);

  localparam logic [CNT_W-1:0]  PIXELS_MAX_C = CNT_W'(PIXELS_MAX);
  localparam logic [WAIT_W-1:0] MIN_WAIT_C   = WAIT_W'(MIN_WAIT);
  localparam logic [WAIT_W-1:0] SOLID_WAIT_C = WAIT_W'((32 < MIN_WAIT) ? MIN_WAIT : 32);
  localparam logic [16:0]       THIRD_MUL    = 17'd43691;
  localparam logic [DIVS_W-1:0] FLASH_LEN    = DIVS_W'(6);

  localparam logic [EFF_W-1:0] EFF_SOLID   = 3'd0;
  localparam logic [EFF_W-1:0] EFF_BLINK   = 3'd1;
  localparam logic [EFF_W-1:0] EFF_FLASH   = 3'd2;
  localparam logic [EFF_W-1:0] EFF_CHASE   = 3'd3;
  localparam logic [EFF_W-1:0] EFF_RAINBOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_EFFECT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAME_HUE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_CNT  = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- src/lsepg_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module lsepg_div import lsepg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0] quot_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;
  logic [DIVS_W-1:0] rem_nxt;

  assign trial   = {rem_r, quot_r[DIVD_W-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVD_W);
        quot_r <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quot_r <= {quot_r[DIVD_W-2:0], fits};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- src/lsepg_color.sv -----
// hue to rgb conversion and brightness scaling
module lsepg_color import lsepg_pkg::*; (
  input  logic [CH_W-1:0]  hue,
  input  logic             use_hue,
  input  logic [RGB_W-1:0] base_rgb,
  input  logic [CH_W-1:0]  brightness,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue
);

  logic [10:0]     hx;
  logic [2:0]      sext;
  logic [CH_W-1:0] frac;
  logic [CH_W-1:0] up;
  logic [CH_W-1:0] dn;
  logic [RGB_W-1:0] hue_rgb;
  logic [RGB_W-1:0] rgb;

  assign hx   = 11'(hue) * 11'd6;
  assign sext = hx[10:8];
  assign frac = hx[7:0];
  assign up   = (frac == '0) ? '0 : frac - 1'b1;
  assign dn   = 8'hFF - frac;

  always_comb begin
    unique case (sext)
      3'd0:    hue_rgb = {8'hFF, up,    8'h00};
      3'd1:    hue_rgb = {dn,    8'hFF, 8'h00};
      3'd2:    hue_rgb = {8'h00, 8'hFF, up};
      3'd3:    hue_rgb = {8'h00, dn,    8'hFF};
      3'd4:    hue_rgb = {up,    8'h00, 8'hFF};
      default: hue_rgb = {8'hFF, 8'h00, dn};
    endcase
  end

  assign rgb = use_hue ? hue_rgb : base_rgb;

  function automatic logic [CH_W-1:0] scale(input logic [CH_W-1:0] c,
                                            input logic [CH_W-1:0] b);
    logic [16:0] t;
    logic [16:0] s;
    t = 17'(c) * 17'(b) + 17'd1;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

  assign red   = scale(rgb[23:16], brightness);
  assign green = scale(rgb[15:8],  brightness);
  assign blue  = scale(rgb[7:0],   brightness);

endmodule

// ----- src/led_strip_effect_pixel_generator.sv -----
// led strip effect pixel generator top level
//
// in channel: one word per pixel request, in_tdata holds the physical pixel
// index, in_tlast marks the last request of a frame. out channel: one word
// per request with the scaled red, green and blue and, on the last pixel,
// the wait in ms until the next frame (zero otherwise). the cfg port writes
// one register per cycle at cfg_index; writing the effect clears the step.
// out_tvalid rises once the result is registered in S_FIN. solid and blink
// go from S_START straight to S_FIN; flash, chase and rainbow first wait in
// S_RUN for the bit-serial divider (18 quotient bits, one per cycle), which
// forms the step remainder or the rainbow hue offset.
// one item is worked at a time; in_tready is high while no item is in work.
// the result register lets the next item start while a result waits.
// when the receiver stalls the finished item holds until out_tready rises.
// with pixel_count zero a request is taken and dropped with no result.
// reset (rst_n low, synchronous) loads brightness 255, base delay 1000,
// clears the effect, colour, flags, pixel count, step and result valid flag.
module led_strip_effect_pixel_generator import lsepg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // pixel_index
  input  logic                  in_tlast,   // frame_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // frame_wait, blue, green, red
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_RUN, S_FIN} state_t;

  state_t             state_r;
  logic [EFF_W-1:0]   effect_r;
  logic [RGB_W-1:0]   color_r;
  logic [CH_W-1:0]    bright_r;
  logic               reverse_r;
  logic               mirror_r;
  logic               same_hue_r;
  logic [WAIT_W-1:0]  base_delay_r;
  logic [CNT_W-1:0]   pix_cnt_r;
  logic [STEP_W-1:0]  step_r;
  logic [IDX_W-1:0]   pix_r;
  logic               last_r;
  logic               out_valid_r;
  logic [39:0]        out_data_r;

  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   lc;
  logic [CNT_W-1:0]   p;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   li;
  logic               off;
  logic               on_strip;
  logic [EFF_W-1:0]   eff;
  logic               need_div;
  logic               out_free;
  logic               out_load;

  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [RGB_W-1:0]   base_rgb;
  logic               use_hue;
  logic [CH_W-1:0]    hue;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic [32:0]        third_prod;
  logic [WAIT_W-1:0]  raw_wait;
  logic [WAIT_W-1:0]  wait_val;
  logic [WAIT_W-1:0]  frame_wait;
  logic [STEP_W-1:0]  step_nxt;
  logic [DIVS_W-1:0]  rem_inc;

  // strip mapping
  assign n   = (pix_cnt_r > PIXELS_MAX_C) ? PIXELS_MAX_C : pix_cnt_r;
  assign off = n[0];
  assign lc  = mirror_r ? ((n >> 1) + CNT_W'(off)) : n;
  assign p   = CNT_W'(pix_r);
  assign on_strip = p < n;

  always_comb begin
    if (!mirror_r) begin
      j = p;
    end else if (p < lc) begin
      j = lc - 1'b1 - p;
    end else begin
      j = p - lc + CNT_W'(off);
    end
  end

  assign li  = reverse_r ? (lc - 1'b1 - j) : j;
  assign eff = (effect_r > EFF_RAINBOW) ? EFF_SOLID : effect_r;
  assign need_div = (eff == EFF_FLASH) || (eff == EFF_CHASE) || (eff == EFF_RAINBOW);

  always_comb begin
    dreq.start    = (state_r == S_START) && (n != '0) && need_div;
    dreq.dividend = (eff == EFF_RAINBOW) ? {li[IDX_W-1:0], 8'h00} : DIVD_W'(step_r);
    dreq.divisor  = (eff == EFF_FLASH) ? FLASH_LEN : lc;
  end

  lsepg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // pixel colour before scaling
  always_comb begin
    base_rgb = '0;
    use_hue  = 1'b0;
    hue      = same_hue_r ? step_r[7:0] : (drsp.quot[7:0] + step_r[7:0]);
    if (on_strip) begin
      case (eff)
        EFF_BLINK: base_rgb = step_r[0] ? '0 : color_r;
        EFF_FLASH: base_rgb = ((drsp.rem == '0) || (drsp.rem == DIVS_W'(2))) ?
                              color_r : '0;
        EFF_CHASE: base_rgb = (li == drsp.rem) ? color_r : '0;
        EFF_RAINBOW: use_hue = 1'b1;
        default:   base_rgb = color_r;
      endcase
    end
  end

  lsepg_color u_color (
    .hue        (hue),
    .use_hue    (use_hue),
    .base_rgb   (base_rgb),
    .brightness (bright_r),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // frame wait and step update
  assign third_prod = 33'(base_delay_r) * 33'(THIRD_MUL);
  assign rem_inc    = drsp.rem + 1'b1;

  always_comb begin
    raw_wait = SOLID_WAIT_C;
    step_nxt = step_r;
    case (eff)
      EFF_BLINK: begin
        raw_wait = base_delay_r;
        step_nxt = step_r + 1'b1;
      end
      EFF_FLASH: begin
        raw_wait = third_prod[32:17];
        step_nxt = (rem_inc == FLASH_LEN) ? '0 : STEP_W'(rem_inc);
      end
      EFF_CHASE: begin
        raw_wait = base_delay_r >> 5;
        step_nxt = STEP_W'(rem_inc);
      end
      EFF_RAINBOW: begin
        raw_wait = base_delay_r >> 8;
        step_nxt = {8'h00, step_r[7:0] + 8'd1};
      end
      default: raw_wait = SOLID_WAIT_C;
    endcase
  end

  assign wait_val   = (raw_wait < MIN_WAIT_C) ? MIN_WAIT_C : raw_wait;
  assign frame_wait = last_r ? wait_val : '0;
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      effect_r     <= EFF_SOLID;
      color_r      <= '0;
      bright_r     <= 8'hFF;
      reverse_r    <= 1'b0;
      mirror_r     <= 1'b0;
      same_hue_r   <= 1'b0;
      base_delay_r <= 16'd1000;
      pix_cnt_r    <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_EFFECT: begin
            effect_r <= cfg_wdata[EFF_W-1:0];
            step_r   <= '0;
          end
          REG_COLOR:      color_r      <= cfg_wdata[RGB_W-1:0];
          REG_BRIGHTNESS: bright_r     <= cfg_wdata[CH_W-1:0];
          REG_REVERSE:    reverse_r    <= cfg_wdata[0];
          REG_MIRROR:     mirror_r     <= cfg_wdata[0];
          REG_SAME_HUE:   same_hue_r   <= cfg_wdata[0];
          REG_BASE_DELAY: base_delay_r <= cfg_wdata[WAIT_W-1:0];
          REG_PIXEL_CNT:  pix_cnt_r    <= cfg_wdata[CNT_W-1:0];
          default:        pix_cnt_r    <= pix_cnt_r;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            pix_r   <= in_tdata[IDX_W-1:0];
            last_r  <= in_tlast;
            state_r <= S_START;
          end
        end
        S_START: begin
          if (n == '0) begin
            state_r <= S_IDLE;
          end else if (need_div) begin
            state_r <= S_RUN;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_RUN: begin
          if (drsp.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= {frame_wait, blue, green, red};
            if (last_r) begin
              step_r <= step_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
